// File: src/tlpc_pkg.sv
// Package for the traffic light controller: phase codes, lamp table, register map.
package tlpc_pkg;

  localparam int DurW  = 16;
  localparam int IdxW  = 3;
  localparam int PhW   = 3;
  localparam int LampW = 6;

  localparam logic [IdxW-1:0] REG_WE_GREEN  = 3'd0;
  localparam logic [IdxW-1:0] REG_NS_GREEN  = 3'd1;
  localparam logic [IdxW-1:0] REG_YELLOW    = 3'd2;
  localparam logic [IdxW-1:0] REG_CLEARANCE = 3'd3;
  localparam logic [IdxW-1:0] REG_CROSSING  = 3'd4;

  localparam logic [DurW-1:0] RST_WE_GREEN  = 16'd4000;
  localparam logic [DurW-1:0] RST_NS_GREEN  = 16'd5000;
  localparam logic [DurW-1:0] RST_YELLOW    = 16'd2000;
  localparam logic [DurW-1:0] RST_CLEARANCE = 16'd500;
  localparam logic [DurW-1:0] RST_CROSSING  = 16'd4000;

  typedef enum logic [7:0] {
    PH_WE_GREEN  = 8'b0000_0001,
    PH_WE_YELLOW = 8'b0000_0010,
    PH_CLEAR1    = 8'b0000_0100,
    PH_NS_GREEN  = 8'b0000_1000,
    PH_NS_YELLOW = 8'b0001_0000,
    PH_CLEAR2    = 8'b0010_0000,
    PH_CROSS1    = 8'b0100_0000,
    PH_CROSS2    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [DurW-1:0] we_green;
    logic [DurW-1:0] ns_green;
    logic [DurW-1:0] yellow;
    logic [DurW-1:0] clearance;
    logic [DurW-1:0] crossing;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   req;
  } status_t;

  function automatic logic [PhW-1:0] phase_code(phase_t p);
    logic [PhW-1:0] c;
    case (p)
      PH_WE_GREEN:  c = 3'd0;
      PH_WE_YELLOW: c = 3'd1;
      PH_CLEAR1:    c = 3'd2;
      PH_NS_GREEN:  c = 3'd3;
      PH_NS_YELLOW: c = 3'd4;
      PH_CLEAR2:    c = 3'd5;
      PH_CROSS1:    c = 3'd6;
      PH_CROSS2:    c = 3'd7;
      default:      c = 3'd0;
    endcase
    return c;
  endfunction

  // bit0 red NS, 1 yellow NS, 2 green NS, 3 red WE, 4 yellow WE, 5 green WE
  function automatic logic [LampW-1:0] phase_lamps(phase_t p);
    logic [LampW-1:0] l;
    case (p)
      PH_WE_GREEN:  l = 6'h21;
      PH_WE_YELLOW: l = 6'h11;
      PH_NS_GREEN:  l = 6'h0C;
      PH_NS_YELLOW: l = 6'h0A;
      default:      l = 6'h09;
    endcase
    return l;
  endfunction

endpackage

// File: src/tlpc_in_stage.sv
// Input register stage: holds one accepted transaction until the phase unit takes it.
module tlpc_in_stage (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_tick,
  input  logic in_button,
  input  logic take,
  output logic held_valid,
  output logic held_tick,
  output logic held_button
);

  logic valid_r, valid_nxt;
  logic tick_r;
  logic button_r;
  logic load;

  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tick_r   <= in_tick;
      button_r <= in_button;
    end
  end

  assign held_valid  = valid_r;
  assign held_tick   = tick_r;
  assign held_button = button_r;

endmodule

// File: src/tlpc_phase_unit.sv
// Phase sequencer: phase state, tick count and latched pedestrian request.
module tlpc_phase_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              tick,
  input  logic              button,
  input  tlpc_pkg::cfg_t    cfg,
  output tlpc_pkg::status_t status_nxt
);

  tlpc_pkg::phase_t phase_r, phase_nxt, succ;
  logic [tlpc_pkg::DurW-1:0] elapsed_r, elapsed_nxt;
  logic [tlpc_pkg::DurW-1:0] dur;
  logic [tlpc_pkg::DurW:0]   count;
  logic req_r, req_nxt, req_set, done;

  assign req_set = req_r || button;
  assign count   = {1'b0, elapsed_r} + {{tlpc_pkg::DurW{1'b0}}, 1'b1};

  always_comb begin
    case (phase_r)
      tlpc_pkg::PH_WE_GREEN:  dur = cfg.we_green;
      tlpc_pkg::PH_NS_GREEN:  dur = cfg.ns_green;
      tlpc_pkg::PH_WE_YELLOW,
      tlpc_pkg::PH_NS_YELLOW: dur = cfg.yellow;
      tlpc_pkg::PH_CLEAR1,
      tlpc_pkg::PH_CLEAR2:    dur = cfg.clearance;
      default:                dur = cfg.crossing;
    endcase
  end

  always_comb begin
    case (phase_r)
      tlpc_pkg::PH_WE_GREEN:  succ = tlpc_pkg::PH_WE_YELLOW;
      tlpc_pkg::PH_WE_YELLOW: succ = tlpc_pkg::PH_CLEAR1;
      tlpc_pkg::PH_CLEAR1:    succ = req_set ? tlpc_pkg::PH_CROSS1 : tlpc_pkg::PH_NS_GREEN;
      tlpc_pkg::PH_NS_GREEN:  succ = tlpc_pkg::PH_NS_YELLOW;
      tlpc_pkg::PH_NS_YELLOW: succ = tlpc_pkg::PH_CLEAR2;
      tlpc_pkg::PH_CLEAR2:    succ = req_set ? tlpc_pkg::PH_CROSS2 : tlpc_pkg::PH_WE_GREEN;
      tlpc_pkg::PH_CROSS1:    succ = tlpc_pkg::PH_NS_GREEN;
      default:                succ = tlpc_pkg::PH_WE_GREEN;
    endcase
  end

  assign done = tick && (count >= {1'b0, dur});

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    req_nxt     = req_set;
    if (done) begin
      phase_nxt   = succ;
      elapsed_nxt = '0;
      if (phase_r == tlpc_pkg::PH_CROSS1 || phase_r == tlpc_pkg::PH_CROSS2) begin
        req_nxt = 1'b0;
      end
    end else if (tick) begin
      elapsed_nxt = count[tlpc_pkg::DurW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= tlpc_pkg::PH_WE_GREEN;
      elapsed_r <= '0;
      req_r     <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      req_r     <= req_nxt;
    end
  end

  assign status_nxt.phase = phase_nxt;
  assign status_nxt.req   = req_nxt;

endmodule

// File: src/traffic_light_pedestrian_controller_core.sv
// Top level of the two-road traffic light controller with pedestrian request.
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_stall | in_tick, in_button
//   out     | output    | out_valid/out_stall | out_lamps, out_phase, out_request_pending
//   cfg     | input     | cfg_we            | cfg_index, cfg_wdata
//
// One transaction per cycle while out_stall is low; each result passes the input
// register, then the result register, set by the phase update between them.
// Synchronous reset restores default durations, WE green, count and request cleared.
// A stalled result holds; one more transaction is buffered in the input register.
module traffic_light_pedestrian_controller_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_tick,
  input  logic                         in_button,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tlpc_pkg::LampW-1:0]   out_lamps,
  output logic [tlpc_pkg::PhW-1:0]     out_phase,
  output logic                         out_request_pending,
  input  logic                         cfg_we,
  input  logic [tlpc_pkg::IdxW-1:0]    cfg_index,
  input  logic [tlpc_pkg::DurW-1:0]    cfg_wdata
);

  tlpc_pkg::cfg_t    cfg_r, cfg_nxt;
  tlpc_pkg::status_t status_nxt;
  logic held_valid, held_tick, held_button, move;
  logic out_valid_r, out_valid_nxt;
  logic [tlpc_pkg::LampW-1:0] lamps_r;
  logic [tlpc_pkg::PhW-1:0]   phase_r;
  logic                       req_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        tlpc_pkg::REG_WE_GREEN:  cfg_nxt.we_green  = cfg_wdata;
        tlpc_pkg::REG_NS_GREEN:  cfg_nxt.ns_green  = cfg_wdata;
        tlpc_pkg::REG_YELLOW:    cfg_nxt.yellow    = cfg_wdata;
        tlpc_pkg::REG_CLEARANCE: cfg_nxt.clearance = cfg_wdata;
        tlpc_pkg::REG_CROSSING:  cfg_nxt.crossing  = cfg_wdata;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.we_green  <= tlpc_pkg::RST_WE_GREEN;
      cfg_r.ns_green  <= tlpc_pkg::RST_NS_GREEN;
      cfg_r.yellow    <= tlpc_pkg::RST_YELLOW;
      cfg_r.clearance <= tlpc_pkg::RST_CLEARANCE;
      cfg_r.crossing  <= tlpc_pkg::RST_CROSSING;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign move = held_valid && (!out_valid_r || !out_stall);

  tlpc_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_tick     (in_tick),
    .in_button   (in_button),
    .take        (move),
    .held_valid  (held_valid),
    .held_tick   (held_tick),
    .held_button (held_button)
  );

  tlpc_phase_unit u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (move),
    .tick       (held_tick),
    .button     (held_button),
    .cfg        (cfg_r),
    .status_nxt (status_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (move) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      lamps_r <= tlpc_pkg::phase_lamps(status_nxt.phase);
      phase_r <= tlpc_pkg::phase_code(status_nxt.phase);
      req_r   <= status_nxt.req;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_lamps           = lamps_r;
  assign out_phase           = phase_r;
  assign out_request_pending = req_r;

endmodule
